// File: hw/rtl/assert_macros.svh
// Assertion helpers shared by the RTL. Clock clk, reset rst_n (active low).
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property that must hold at every rising edge outside reset.
`define TNC_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
    else $error("tnc assertion failed");

// Property that is checked through reset as well.
`define TNC_ASSERT_ALWAYS(lbl, prop) \
  lbl: assert property (@(posedge clk) (prop)) \
    else $error("tnc assertion failed");

`endif

// File: hw/rtl/tnc_pkg.sv
package tnc_pkg;

  localparam int CW       = 16;          // coordinate width, Q8.8
  localparam int F        = 14;          // normal fraction bits
  localparam int NW       = F + 2;       // normal component width
  localparam int EW       = CW + 1;      // edge vector width
  localparam int PW       = 2 * EW;      // edge product width
  localparam int XW       = PW + 1;      // signed cross component width
  localparam int MW       = XW - 1;      // cross magnitude width
  localparam int MGW      = 31;          // magnitude after range shift
  localparam int LW       = $clog2(MW + 1);
  localparam int SQW      = 2 * MGW;     // square of one magnitude
  localparam int SW       = SQW + 2;     // sum of three squares
  localparam int HW       = SW / 2;      // half of the sum, for partial products
  localparam int TW       = F + 1;       // candidate and odd term width
  localparam int T2W      = 2 * TW;
  localparam int PPW      = T2W + HW;    // partial product width
  localparam int PRW      = T2W + SW;    // full t^2 * S width
  localparam int CSW      = CW + 2;      // three-way coordinate sum
  localparam int RECIP    = 174763;      // ceil(2^19 / 3)
  localparam int RSH      = 19;
  localparam int RCW      = 18;
  localparam int CPW      = CSW + RCW;

  localparam int STEPS    = F + 1;       // one result bit per step
  localparam int FRONT_ST = 6;
  localparam int LANE_ST  = 3 * STEPS;
  localparam int NST      = FRONT_ST + LANE_ST + 1;

  localparam int IN_DW    = ((9 * CW + 7) / 8) * 8;
  localparam int OUT_DW   = ((3 * NW + 3 * CW + 7) / 8) * 8;

  typedef struct packed {
    logic [2:0]         neg;
    logic               degen;
    logic [2:0][CW-1:0] center;
  } side_t;

  typedef struct packed {
    logic [2:0][SQW-1:0] n2;
    logic [SW-1:0]       s;
    side_t               sd;
  } front_t;

endpackage

// File: hw/rtl/tnc_front.sv
module tnc_front (
  input  logic                                    clk,
  input  logic [tnc_pkg::FRONT_ST-1:0]            en,
  input  logic [8:0][tnc_pkg::CW-1:0]             vtx,
  output tnc_pkg::front_t                         fo
);
  import tnc_pkg::*;

  logic signed [EW-1:0]  u_r [3];
  logic signed [EW-1:0]  w_r [3];
  logic signed [CSW-1:0] sum_r [3];
  logic signed [PW-1:0]  p_r [6];
  logic [CPW-1:0]        cprod_r [3];
  logic [2:0]            cneg_r;
  logic [MW-1:0]         mag3_r [3];
  logic [MGW-1:0]        mg4_r [3];
  logic [SQW-1:0]        sq5_r [3];
  logic [SQW-1:0]        sq6_r [3];
  logic [SW-1:0]         s6_r;
  side_t                 sd3_r, sd4_r, sd5_r, sd6_r;

  logic [CSW-1:0]        cabs [3];
  logic signed [XW-1:0]  nx [3];
  logic [CW:0]           cq [3];
  logic [MW-1:0]         orv;
  logic [LW-1:0]         len;
  logic [LW-1:0]         sh;

  // stage 1: edges and coordinate sums
  always_ff @(posedge clk) begin
    if (en[0]) begin
      for (int i = 0; i < 3; i++) begin
        u_r[i]   <= EW'(signed'(vtx[3+i])) - EW'(signed'(vtx[i]));
        w_r[i]   <= EW'(signed'(vtx[6+i])) - EW'(signed'(vtx[i]));
        sum_r[i] <= CSW'(signed'(vtx[i])) + CSW'(signed'(vtx[3+i]))
                  + CSW'(signed'(vtx[6+i]));
      end
    end
  end

  // stage 2: edge products, centroid reciprocal multiply
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      cabs[i] = (sum_r[i][CSW-1] ? CSW'(-sum_r[i]) : CSW'(sum_r[i])) + CSW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (en[1]) begin
      p_r[0] <= u_r[1] * w_r[2];
      p_r[1] <= u_r[2] * w_r[1];
      p_r[2] <= u_r[2] * w_r[0];
      p_r[3] <= u_r[0] * w_r[2];
      p_r[4] <= u_r[0] * w_r[1];
      p_r[5] <= u_r[1] * w_r[0];
      for (int i = 0; i < 3; i++) begin
        cprod_r[i] <= CPW'(cabs[i]) * CPW'(RECIP);
        cneg_r[i]  <= sum_r[i][CSW-1];
      end
    end
  end

  // stage 3: cross components as sign and magnitude, centroid quotient
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      nx[i] = XW'(p_r[2*i]) - XW'(p_r[2*i+1]);
      cq[i] = (CW+1)'(cprod_r[i] >> RSH);
    end
  end

  always_ff @(posedge clk) begin
    if (en[2]) begin
      for (int i = 0; i < 3; i++) begin
        mag3_r[i]        <= nx[i][XW-1] ? MW'(-nx[i]) : MW'(nx[i]);
        sd3_r.neg[i]     <= nx[i][XW-1];
        sd3_r.center[i]  <= cneg_r[i] ? CW'(-cq[i]) : CW'(cq[i]);
      end
      // zero cross product: degenerate triangle
      sd3_r.degen <= (nx[0] == '0) && (nx[1] == '0) && (nx[2] == '0);
    end
  end

  // stage 4: bring the largest magnitude below 2^31
  always_comb begin
    orv = mag3_r[0] | mag3_r[1] | mag3_r[2];
    len = '0;
    for (int b = 0; b < MW; b++) begin
      if (orv[b]) len = LW'(b + 1);
    end
    sh = (len > LW'(MGW)) ? len - LW'(MGW) : '0;
  end

  always_ff @(posedge clk) begin
    if (en[3]) begin
      for (int i = 0; i < 3; i++) mg4_r[i] <= MGW'(mag3_r[i] >> sh);
      sd4_r <= sd3_r;
    end
  end

  // stage 5: squares
  always_ff @(posedge clk) begin
    if (en[4]) begin
      for (int i = 0; i < 3; i++) sq5_r[i] <= SQW'(mg4_r[i]) * SQW'(mg4_r[i]);
      sd5_r <= sd4_r;
    end
  end

  // stage 6: sum of squares
  always_ff @(posedge clk) begin
    if (en[5]) begin
      for (int i = 0; i < 3; i++) sq6_r[i] <= sq5_r[i];
      s6_r  <= SW'(sq5_r[0]) + SW'(sq5_r[1]) + SW'(sq5_r[2]);
      sd6_r <= sd5_r;
    end
  end

  always_comb begin
    for (int i = 0; i < 3; i++) fo.n2[i] = sq6_r[i];
    fo.s  = s6_r;
    fo.sd = sd6_r;
  end

endmodule

// File: hw/rtl/tnc_lane.sv
module tnc_lane (
  input  logic                          clk,
  input  logic [tnc_pkg::LANE_ST-1:0]   en,
  input  logic [tnc_pkg::SQW-1:0]       n2_i,
  input  logic [tnc_pkg::SW-1:0]        s_i,
  output logic [tnc_pkg::TW-1:0]        m_o
);
  import tnc_pkg::*;

  // per step: A squares the odd term, B forms partial products with S,
  // C compares against n^2 * 2^(2F+2) and keeps or drops the bit
  logic [TW-1:0]  mi   [STEPS];
  logic [SQW-1:0] n2i  [STEPS];
  logic [SW-1:0]  si   [STEPS];

  logic [TW-1:0]  ca_r [STEPS];
  logic [TW-1:0]  ma_r [STEPS];
  logic [T2W-1:0] t2_r [STEPS];
  logic           ska_r[STEPS];
  logic [SQW-1:0] n2a_r[STEPS];
  logic [SW-1:0]  sa_r [STEPS];

  logic [TW-1:0]  cb_r [STEPS];
  logic [TW-1:0]  mb_r [STEPS];
  logic [PPW-1:0] ppl_r[STEPS];
  logic [PPW-1:0] pph_r[STEPS];
  logic           skb_r[STEPS];
  logic [SQW-1:0] n2b_r[STEPS];
  logic [SW-1:0]  sb_r [STEPS];

  logic [TW-1:0]  m_r  [STEPS];
  logic [SQW-1:0] n2c_r[STEPS];
  logic [SW-1:0]  sc_r [STEPS];

  for (genvar k = 0; k < STEPS; k++) begin : g_step
    localparam int BIT = F - k;
    logic [TW-1:0]  cand;
    logic [TW-1:0]  t;
    logic [PRW-1:0] prod;
    logic [PRW-1:0] rhs;

    if (k == 0) begin : g_first
      assign mi[k]  = '0;
      assign n2i[k] = n2_i;
      assign si[k]  = s_i;
    end else begin : g_next
      assign mi[k]  = m_r[k-1];
      assign n2i[k] = n2c_r[k-1];
      assign si[k]  = sc_r[k-1];
    end

    assign cand = mi[k] | (TW'(1) << BIT);
    assign t    = TW'({cand, 1'b0} - {(TW)'(0), 1'b1});

    always_ff @(posedge clk) begin
      if (en[3*k]) begin
        ca_r[k]  <= cand;
        ma_r[k]  <= mi[k];
        t2_r[k]  <= T2W'(t) * T2W'(t);
        ska_r[k] <= mi[k][F];      // m already at 1.0
        n2a_r[k] <= n2i[k];
        sa_r[k]  <= si[k];
      end
    end

    always_ff @(posedge clk) begin
      if (en[3*k+1]) begin
        cb_r[k]  <= ca_r[k];
        mb_r[k]  <= ma_r[k];
        ppl_r[k] <= PPW'(t2_r[k]) * PPW'(sa_r[k][HW-1:0]);
        pph_r[k] <= PPW'(t2_r[k]) * PPW'(sa_r[k][SW-1:HW]);
        skb_r[k] <= ska_r[k];
        n2b_r[k] <= n2a_r[k];
        sb_r[k]  <= sa_r[k];
      end
    end

    assign prod = PRW'(ppl_r[k]) + (PRW'(pph_r[k]) << HW);
    assign rhs  = PRW'({n2b_r[k], (2*F+2)'(0)});

    always_ff @(posedge clk) begin
      if (en[3*k+2]) begin
        m_r[k]   <= (!skb_r[k] && (prod <= rhs)) ? cb_r[k] : mb_r[k];
        n2c_r[k] <= n2b_r[k];
        sc_r[k]  <= sb_r[k];
      end
    end
  end

  assign m_o = m_r[STEPS-1];

endmodule

// File: hw/rtl/triangle_normal_centroid.sv
// Triangle face normal and centroid.
// Input channel in_*: one item is one triangle, nine signed Q8.8
// coordinates packed in in_tdata (a.x lowest, then a.y, a.z, b.x ... c.z).
// Output channel out_*: unit normal x, y, z in signed Q1.14 and centroid
// x, y, z in signed Q8.8 in out_tdata; out_tuser is the degenerate flag,
// set when the cross product is zero and the normal is forced to zero.
// Throughput: one item per cycle while out_tready is high. Every stage
// holds its own valid bit and takes a new item whenever it is empty or its
// successor moves, so bubbles close up and a finished result waiting at
// the output does not stop accepting while any stage downstream is empty.
// Stages from acceptance to out_tvalid: 6 front stages
// (edges, products, cross, range shift, squares, sum), 45 normalise stages
// (15 result bits, 3 stages each for square, partial products, compare),
// 1 output stage.
// Stall: while out_tready is low, a stage holds when it and every later
// stage are full, and in_tready drops once all are. Reset (rst_n low,
// synchronous) empties the pipeline; nothing is kept between items.
module triangle_normal_centroid (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_tvalid,
  output logic                        in_tready,
  // a.x, a.y, a.z, b.x, b.y, b.z, c.x, c.y, c.z
  input  logic [tnc_pkg::IN_DW-1:0]   in_tdata,
  output logic                        out_tvalid,
  input  logic                        out_tready,
  // normal_x, normal_y, normal_z, center_x, center_y, center_z
  output logic [tnc_pkg::OUT_DW-1:0]  out_tdata,
  // degenerate
  output logic                        out_tuser
);
  import tnc_pkg::*;

  logic [NST-1:0]        v_r;
  logic [NST:0]          en;
  logic [8:0][CW-1:0]    vtx;
  front_t                fo;
  logic [TW-1:0]         m [3];
  side_t                 sd_r [LANE_ST];
  logic [NW-1:0]         nrm [3];
  logic [OUT_DW-1:0]     out_tdata_r;
  logic                  out_tuser_r;

  // stage advance: a stage loads when it is empty or the next one loads
  always_comb begin
    en[NST] = out_tready;
    for (int i = NST - 1; i >= 0; i--) en[i] = !v_r[i] || en[i+1];
  end

  assign in_tready  = en[0];
  assign out_tvalid = v_r[NST-1];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else begin
      if (en[0]) v_r[0] <= in_tvalid;
      for (int i = 1; i < NST; i++) begin
        if (en[i]) v_r[i] <= v_r[i-1];
      end
    end
  end

  always_comb begin
    for (int i = 0; i < 9; i++) vtx[i] = in_tdata[i*CW +: CW];
  end

  tnc_front u_front (
    .clk (clk),
    .en  (en[FRONT_ST-1:0]),
    .vtx (vtx),
    .fo  (fo)
  );

  // one lane per normal component
  for (genvar l = 0; l < 3; l++) begin : g_lane
    tnc_lane u_lane (
      .clk  (clk),
      .en   (en[FRONT_ST+LANE_ST-1:FRONT_ST]),
      .n2_i (fo.n2[l]),
      .s_i  (fo.s),
      .m_o  (m[l])
    );
  end

  // signs, flag and centroid ride alongside the lanes
  always_ff @(posedge clk) begin
    for (int j = 0; j < LANE_ST; j++) begin
      if (en[FRONT_ST+j]) sd_r[j] <= (j == 0) ? fo.sd : sd_r[(j == 0) ? 0 : j-1];
    end
  end

  // merge: apply signs, force zero on a degenerate triangle
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      if (sd_r[LANE_ST-1].degen) begin
        nrm[i] = '0;
      end else if (sd_r[LANE_ST-1].neg[i]) begin
        nrm[i] = NW'(-NW'(m[i]));
      end else begin
        nrm[i] = NW'(m[i]);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en[NST-1]) begin
      out_tdata_r <= OUT_DW'({sd_r[LANE_ST-1].center[2], sd_r[LANE_ST-1].center[1],
                              sd_r[LANE_ST-1].center[0], nrm[2], nrm[1], nrm[0]});
      out_tuser_r <= sd_r[LANE_ST-1].degen;
    end
  end

  assign out_tdata = out_tdata_r;
  assign out_tuser = out_tuser_r;

`include "assert_macros.svh"

  `TNC_ASSERT(a_degen_zero, (out_tvalid && out_tuser) |-> (out_tdata[3*NW-1:0] == '0))
  `TNC_ASSERT(a_normal_nonzero, (out_tvalid && !out_tuser) |-> (out_tdata[3*NW-1:0] != '0))
  `TNC_ASSERT_ALWAYS(a_reset_empty, !rst_n |=> !out_tvalid)

endmodule

// File: tb/triangle_normal_centroid_tb.sv
module triangle_normal_centroid_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import tnc_pkg::*;

  localparam int WATCHDOG_LIMIT = 4000;   // cycles with no item moving
  localparam int DRAIN_CYCLES   = 60;     // extra wait after the queue empties
  localparam int HOLD_CYCLES    = 300;    // long receiver hold-off

  typedef logic [8:0][CW-1:0] tri_coords_t;   // a.x lowest ... c.z

  typedef struct {
    logic [OUT_DW-1:0] data;
    logic              degen;
  } face_result_t;

  logic                clk = 1'b0;
  logic                rst_n = 1'b0;
  logic                in_tvalid = 1'b0;
  logic                in_tready;
  // a.x, a.y, a.z, b.x, b.y, b.z, c.x, c.y, c.z
  logic [IN_DW-1:0]    in_tdata = '0;
  logic                out_tvalid;
  logic                out_tready = 1'b0;
  // normal_x, normal_y, normal_z, center_x, center_y, center_z
  logic [OUT_DW-1:0]   out_tdata;
  // degenerate
  logic                out_tuser;

  face_result_t face_q[$];     // predicted faces in flight
  int  errors = 0;
  int  idle_cnt = 0;
  bit  send_idle = 1'b1;       // sender gaps allowed
  bit  recv_idle = 1'b1;       // receiver stalls allowed
  bit  hold_req = 1'b0;        // ask receiver for a long hold-off

  triangle_normal_centroid uut (
    .clk(clk), .rst_n(rst_n),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tdata(in_tdata),
    .out_tvalid(out_tvalid), .out_tready(out_tready),
    .out_tdata(out_tdata), .out_tuser(out_tuser)
  );

  always #4 clk = ~clk;

  // Face predictor: exact cross product, range shift to 31 bits, bitwise
  // nearest-integer unit scaling, and rounded centroid.
  function automatic face_result_t predict_face(input tri_coords_t vtx);
    face_result_t r;
    longint v[9];
    longint u[3], w[3], cr[3];
    longint unsigned mg[3], s, m, cand, t;
    logic [127:0] lhs, rhs;
    int len, sh, k, b;
    longint sum, q;
    for (k = 0; k < 9; k++) v[k] = longint'($signed(vtx[k]));
    for (k = 0; k < 3; k++) begin
      u[k] = v[3+k] - v[k];
      w[k] = v[6+k] - v[k];
    end
    cr[0] = u[1]*w[2] - u[2]*w[1];
    cr[1] = u[2]*w[0] - u[0]*w[2];
    cr[2] = u[0]*w[1] - u[1]*w[0];
    r.data = '0;
    for (k = 0; k < 3; k++) begin
      sum = v[k] + v[3+k] + v[6+k];
      if (sum >= 0) q = (sum + 1) / 3;
      else q = -((-sum + 1) / 3);
      r.data[3*NW + k*CW +: CW] = q[CW-1:0];
    end
    len = 0;
    for (k = 0; k < 3; k++) begin
      mg[k] = (cr[k] < 0) ? longint'(-cr[k]) : longint'(cr[k]);
      for (b = 63; b >= 0; b--)
        if (mg[k][b]) begin
          if (b + 1 > len) len = b + 1;
          break;
        end
    end
    if (len == 0) begin
      r.degen = 1'b1;
      return r;
    end
    r.degen = 1'b0;
    sh = (len > 31) ? len - 31 : 0;
    s = 0;
    for (k = 0; k < 3; k++) begin
      mg[k] = mg[k] >> sh;
      s += mg[k] * mg[k];
    end
    for (k = 0; k < 3; k++) begin
      rhs = 128'(mg[k] * mg[k]) << (2*F + 2);
      m = 0;
      for (b = F; b >= 0; b--) begin
        cand = m | (64'd1 << b);
        if (cand > (64'd1 << F)) continue;
        t = 2*cand - 1;
        lhs = 128'(t * t) * 128'(s);
        if (lhs <= rhs) m = cand;
      end
      if (cr[k] < 0) m = -m;
      r.data[k*NW +: NW] = m[NW-1:0];
    end
    return r;
  endfunction

  // One triangle: offer at the falling edge, hold until accepted.
  task automatic send_triangle(input tri_coords_t vtx);
    @(negedge clk);
    if (send_idle && $urandom_range(0, 5) == 0) begin
      in_tvalid = 1'b0;
      repeat ($urandom_range(1, 16)) @(negedge clk);
    end
    in_tvalid = 1'b1;
    in_tdata  = IN_DW'(vtx);
    do @(posedge clk); while (!in_tready);
    face_q.push_back(predict_face(vtx));
    idle_cnt = 0;
  endtask

  // Random triangle: full range, small and local, or degenerate shapes.
  function automatic tri_coords_t rand_triangle();
    tri_coords_t vtx;
    int k, mode, span;
    mode = $urandom_range(0, 9);
    span = (mode < 6) ? 255 : 4095;
    for (k = 0; k < 9; k++) vtx[k] = CW'($urandom);
    if (mode >= 3 && mode < 8)
      for (k = 3; k < 9; k++)
        vtx[k] = vtx[k % 3] + CW'($urandom_range(0, 2*span) - span);
    if (mode == 8) begin
      // collinear: c = a + 2 (b - a), kept small
      for (k = 0; k < 3; k++) begin
        vtx[3+k] = vtx[k] + CW'($urandom_range(0, 200) - 100);
        vtx[6+k] = vtx[k] + 2 * (vtx[3+k] - vtx[k]);
      end
    end
    if (mode == 9) begin
      // two coincident vertices
      for (k = 0; k < 3; k++) vtx[6+k] = vtx[$urandom_range(0, 1)*3 + k];
    end
    return vtx;
  endfunction

  // Receiver: random stall bursts, plus the long hold-off on request.
  initial begin
    forever begin
      @(negedge clk);
      if (hold_req) begin
        out_tready = 1'b0;
        repeat (HOLD_CYCLES) @(negedge clk);
        out_tready = 1'b1;
        hold_req = 1'b0;
      end else if (recv_idle && rst_n && $urandom_range(0, 7) == 0) begin
        out_tready = 1'b0;
        repeat ($urandom_range(1, 16) - 1) @(negedge clk);
      end else begin
        out_tready = 1'b1;
      end
    end
  end

  // Result checker: compare each accepted item with the oldest prediction.
  always @(posedge clk) begin
    face_result_t e;
    if (rst_n && out_tvalid && out_tready) begin
      idle_cnt = 0;
      if (face_q.size() == 0) begin
        $display("%0t: unexpected result data=%h degen=%b", $time, out_tdata, out_tuser);
        errors++;
      end else begin
        e = face_q.pop_front();
        for (int k = 0; k < 6; k++)
          if (out_tdata[k*16 +: 16] !== e.data[k*16 +: 16]) begin
            $display("%0t: field %0d (normal x,y,z then centre x,y,z) expected %h got %h",
                     $time, k, e.data[k*16 +: 16], out_tdata[k*16 +: 16]);
            errors++;
          end
        if (out_tuser !== e.degen) begin
          $display("%0t: degenerate expected %b got %b", $time, e.degen, out_tuser);
          errors++;
        end
      end
    end
  end

  // Watchdog on cycles where nothing moves.
  always @(posedge clk) begin
    idle_cnt++;
    if (idle_cnt > WATCHDOG_LIMIT) begin
      $display("triangle_normal_centroid verification failed");
      $finish;
    end
  end

  task automatic test_reset();
    rst_n = 1'b0;
    repeat (5) @(negedge clk);
    rst_n = 1'b1;
  endtask

  // Extremes, degenerate shapes, axis normals and the range-shift case.
  task automatic test_directed();
    tri_coords_t vtx;
    send_triangle('0);                                   // all zero
    send_triangle({9{16'h7fff}});                        // all max
    send_triangle({9{16'h8000}});                        // all min
    vtx = '0; vtx[3] = 16'h0100; vtx[7] = 16'h0100;      // +z normal
    send_triangle(vtx);
    vtx = '0; vtx[4] = 16'h0100; vtx[6] = 16'h0100;      // -z normal
    send_triangle(vtx);
    vtx = '0; vtx[4] = 16'h0001; vtx[8] = 16'h0001;      // +x, tiny
    send_triangle(vtx);
    vtx = '0; vtx[5] = 16'h0100; vtx[6] = 16'h0100;      // +y normal
    send_triangle(vtx);
    vtx = {16'h7fff, 16'h8000, 16'h8000, 16'h8000, 16'h7fff, 16'h8000,
           16'h8000, 16'h8000, 16'h7fff};                // huge cross, shifted
    send_triangle(vtx);
    vtx = {16'h8000, 16'h7fff, 16'h7fff, 16'h7fff, 16'h8000, 16'h7fff,
           16'h7fff, 16'h7fff, 16'h8000};
    send_triangle(vtx);
    vtx = {16'h0300, 16'h0300, 16'h0300, 16'h0200, 16'h0200, 16'h0200,
           16'h0100, 16'h0100, 16'h0100};                // collinear
    send_triangle(vtx);
    vtx = {16'h0010, 16'hfff0, 16'h1234, 16'h0010, 16'hfff0, 16'h1234,
           16'h0010, 16'hfff0, 16'h1234};                // coincident
    send_triangle(vtx);
    vtx = {16'hffff, 16'h0001, 16'hfffe, 16'h0002, 16'hffff, 16'h0000,
           16'h0001, 16'h0002, 16'hffff};                // centroid rounding
    send_triangle(vtx);
    vtx = {16'h5555, 16'haaaa, 16'h5555, 16'haaaa, 16'h5555, 16'haaaa,
           16'h0f0f, 16'hf0f0, 16'h3c3c};
    send_triangle(vtx);
    send_triangle(~vtx);
    vtx = '0; vtx[3] = 16'h0001; vtx[4] = 16'h0001; vtx[8] = 16'h0001;
    send_triangle(vtx);                                  // diagonal normal
  endtask

  task automatic test_random(input int count);
    repeat (count) send_triangle(rand_triangle());
  endtask

  // Long output hold-off while the sender keeps offering.
  task automatic test_backpressure();
    send_idle = 1'b0;
    hold_req = 1'b1;
    repeat (150) send_triangle(rand_triangle());
    send_idle = 1'b1;
  endtask

  // Closing stretch at full rate on both sides.
  task automatic test_full_rate();
    send_idle = 1'b0;
    recv_idle = 1'b0;
    repeat (200) send_triangle(rand_triangle());
  endtask

  initial begin
    int waited;
    test_reset();
    test_directed();
    test_random(500);
    test_backpressure();
    test_random(500);
    test_full_rate();
    @(negedge clk);
    in_tvalid = 1'b0;
    waited = 0;
    while (face_q.size() != 0 && waited < 20000) begin
      @(posedge clk);
      waited++;
    end
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (face_q.size() != 0) begin
      $display("%0t: %0d results never arrived", $time, face_q.size());
      errors++;
    end
    if (errors == 0) begin
      $display("triangle_normal_centroid verification clean");
    end else begin
      $display("triangle_normal_centroid verification failed");
    end
    $finish;
  end

endmodule
